/* design/paged_allocator_with_translation_top_macros.svh */
// Assertion helpers for the paged allocator
`ifndef PAGED_ALLOCATOR_WITH_TRANSLATION_TOP_MACROS_SVH
`define PAGED_ALLOCATOR_WITH_TRANSLATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PAWT_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PAWT_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PAWT_ASSERT_IMP(lbl, ck, rn, a, c)
`define PAWT_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

/* design/pawt_pkg.sv */
package pawt_pkg;

  // fixed address geometry
  localparam int OFFSET_BITS  = 8;
  localparam int ADDRESS_BITS = 16;
  localparam int VPAGE_BITS   = ADDRESS_BITS - OFFSET_BITS;
  localparam logic [15:0] HEAP_RESET = 16'd256;

  // commands
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REJECT,
    S_ALLOC_CHK,
    S_ALLOC_RD,
    S_ALLOC_TST,
    S_ALLOC_END,
    S_FREE_LK,
    S_FREE_TST,
    S_FREE_CHK,
    S_RW_LK,
    S_RD_WAIT
  } state_t;

endpackage

/* design/pawt_ram.sv */
module pawt_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/paged_allocator_with_translation_top.sv */
// Paged allocator with per-process address translation.
// Input: a request is taken when start is high and busy is low. Fields:
// command (alloc, free, read, write), process id, size, virtual address
// and write byte. Output: one result per request, shown for exactly one
// cycle with out_valid high; the receiver cannot stall it.
// Configuration: cfg_heap_start is written on cfg_valid & cfg_ready and
// reloads every process break pointer; it is taken while no request is
// in flight, also during the reset clear pass.
// Sequence: invalid process, failed or zero-size alloc, and unmapped
// free, read or write reply after the first check; write ends on the
// translation, read waits for the byte read; alloc scans the physical
// pages in order until enough are claimed or all are scanned; free
// releases pages along the chain up to its end or a page whose map or
// owner does not match. One request at a time: the next is taken in the
// cycle out_valid is high. The owner table is walked page by page, a
// read state then a test state each, through its registered read port.
// Reset: a clear pass sweeps byte store, page map and owner table, one
// entry a cycle (65536 entries by default); busy stays high meanwhile.
`include "paged_allocator_with_translation_top_macros.svh"
module paged_allocator_with_translation_top #(
  parameter int PHYS_PAGES = 256,
  parameter int PROCESSES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_process_id,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_virtual_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_region_address,
  output logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_heap_start
);

  localparam int OFB   = pawt_pkg::OFFSET_BITS;
  localparam int VPB   = pawt_pkg::VPAGE_BITS;
  localparam int PGW   = $clog2(PHYS_PAGES);
  localparam int LW    = $clog2(PHYS_PAGES + 1);
  localparam int PIW   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int MAPD  = (1 << PIW) << VPB;
  localparam int MAW   = PIW + VPB;
  localparam int STORE = PHYS_PAGES << OFB;
  localparam int BAW   = $clog2(STORE);
  localparam int CLRN  = (STORE > MAPD) ? STORE : MAPD;
  localparam int CLW   = $clog2(CLRN);
  localparam int MEW   = PGW + 1;
  localparam int CMPW  = (LW > 10) ? LW : 10;
  localparam logic [18:0] SPACE = 19'(1 << pawt_pkg::ADDRESS_BITS);

  pawt_pkg::state_t state_r, state_nxt;

  logic [CLW-1:0] clr_r;
  logic [16:0]    bp_r [PROCESSES];
  logic [LW-1:0]  free_r, free_nxt;
  logic [1:0]     cmd_r, cmd_nxt;
  logic [3:0]     pid_r, pid_nxt;
  logic [PIW-1:0] proc_r, proc_nxt;
  logic [16:0]    size_r, size_nxt;
  logic [15:0]    va_r, va_nxt;
  logic [7:0]     wb_r, wb_nxt;
  logic [9:0]     need_r, need_nxt;
  logic [15:0]    region_r, region_nxt;
  logic [LW-1:0]  pg_r, pg_nxt;
  logic [PGW-1:0] prev_r, prev_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic [VPB:0]   vcur_r, vcur_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [15:0] out_region_r, out_region_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;

  logic            bp_we;
  logic [16:0]     bp_wdata;

  logic            own_we;
  logic [PGW-1:0]  own_wa, own_ra;
  logic [3:0]      own_wd, own_rd;
  logic            lnk_we;
  logic [PGW-1:0]  lnk_wa;
  logic [LW-1:0]   lnk_wd, lnk_rd;
  logic            map_we;
  logic [MAW-1:0]  map_wa, map_ra;
  logic [MEW-1:0]  map_wd, map_rd;
  logic            byt_we;
  logic [BAW-1:0]  byt_wa, byt_ra;
  logic [7:0]      byt_wd, byt_rd;

  logic [3:0]      pid_m1;
  logic [PIW-1:0]  in_proc;
  logic            pid_bad;
  logic [17:0]     size_up;
  logic [9:0]      need_w;
  logic [16:0]     bp_cur;
  logic [18:0]     bp_end;
  logic            alloc_fail;
  logic            page_free;
  logic [LW-1:0]   k_inc;
  logic [LW-1:0]   pg_inc;
  logic            cfg_fire;

  assign pid_m1   = in_process_id - 4'd1;
  assign in_proc  = PIW'(pid_m1);
  assign pid_bad  = (in_process_id == 4'd0) || (32'(in_process_id) > PROCESSES);
  assign size_up  = {1'b0, size_r} + 18'd255;
  assign need_w   = size_up[17:8];
  assign bp_cur   = bp_r[proc_r];
  assign bp_end   = {2'b00, bp_cur} + {1'b0, need_w, 8'd0};
  assign alloc_fail = (CMPW'(need_w) > CMPW'(free_r)) || (bp_end > SPACE);
  assign page_free = (own_rd == 4'd0);
  assign k_inc    = k_r + LW'(1);
  assign pg_inc   = pg_r + LW'(1);
  assign cfg_ready = (state_r == pawt_pkg::S_IDLE) || (state_r == pawt_pkg::S_CLEAR);
  assign cfg_fire  = cfg_valid && cfg_ready;

  // table memories
  pawt_ram #(.DW(4), .DEPTH(PHYS_PAGES)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
    .raddr(own_ra), .rdata(own_rd)
  );
  pawt_ram #(.DW(LW), .DEPTH(PHYS_PAGES)) u_link (
    .clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
    .raddr(pg_r[PGW-1:0]), .rdata(lnk_rd)
  );
  pawt_ram #(.DW(MEW), .DEPTH(MAPD)) u_map (
    .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
    .raddr(map_ra), .rdata(map_rd)
  );
  pawt_ram #(.DW(8), .DEPTH(STORE)) u_bytes (
    .clk(clk), .we(byt_we), .waddr(byt_wa), .wdata(byt_wd),
    .raddr(byt_ra), .rdata(byt_rd)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pawt_pkg::S_CLEAR;
      clr_r       <= '0;
      free_r      <= LW'(PHYS_PAGES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= (state_r == pawt_pkg::S_CLEAR) ? clr_r + CLW'(1) : clr_r;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request payload and walk registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pid_r        <= pid_nxt;
    proc_r       <= proc_nxt;
    size_r       <= size_nxt;
    va_r         <= va_nxt;
    wb_r         <= wb_nxt;
    need_r       <= need_nxt;
    region_r     <= region_nxt;
    pg_r         <= pg_nxt;
    prev_r       <= prev_nxt;
    k_r          <= k_nxt;
    vcur_r       <= vcur_nxt;
    out_status_r <= out_status_nxt;
    out_region_r <= out_region_nxt;
    out_byte_r   <= out_byte_nxt;
  end

  // break pointers: reload all on config, update one on alloc
  always_ff @(posedge clk) begin
    for (int i = 0; i < PROCESSES; i++) begin
      if (!rst_n) begin
        bp_r[i] <= {1'b0, pawt_pkg::HEAP_RESET};
      end else if (cfg_fire) begin
        bp_r[i] <= {1'b0, cfg_heap_start};
      end else if (bp_we && (32'(proc_r) == i)) begin
        bp_r[i] <= bp_wdata;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    free_nxt       = free_r;
    cmd_nxt        = cmd_r;
    pid_nxt        = pid_r;
    proc_nxt       = proc_r;
    size_nxt       = size_r;
    va_nxt         = va_r;
    wb_nxt         = wb_r;
    need_nxt       = need_r;
    region_nxt     = region_r;
    pg_nxt         = pg_r;
    prev_nxt       = prev_r;
    k_nxt          = k_r;
    vcur_nxt       = vcur_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_region_nxt = out_region_r;
    out_byte_nxt   = out_byte_r;
    bp_we          = 1'b0;
    bp_wdata       = bp_end[16:0];
    own_we = 1'b0; own_wa = pg_r[PGW-1:0]; own_wd = 4'd0; own_ra = pg_r[PGW-1:0];
    lnk_we = 1'b0; lnk_wa = prev_r;        lnk_wd = pg_r;
    map_we = 1'b0; map_wa = {proc_r, vcur_r[VPB-1:0]}; map_wd = '0;
    map_ra = {proc_r, vcur_r[VPB-1:0]};
    byt_we = 1'b0; byt_wa = {map_rd[PGW-1:0], va_r[OFB-1:0]}; byt_wd = wb_r;
    byt_ra = {map_rd[PGW-1:0], va_r[OFB-1:0]};

    case (state_r)
      // sweep owner, map and byte memories to zero
      pawt_pkg::S_CLEAR: begin
        own_we = (32'(clr_r) < PHYS_PAGES);
        own_wa = clr_r[PGW-1:0];
        map_we = (32'(clr_r) < MAPD);
        map_wa = clr_r[MAW-1:0];
        byt_we = (32'(clr_r) < STORE);
        byt_wa = clr_r[BAW-1:0];
        byt_wd = 8'd0;
        if (32'(clr_r) == CLRN - 1) begin
          state_nxt = pawt_pkg::S_IDLE;
        end
      end

      // take a request and start the map lookup
      pawt_pkg::S_IDLE: begin
        map_ra = {in_proc, in_virtual_address[15:OFB]};
        if (start) begin
          cmd_nxt  = in_command;
          pid_nxt  = in_process_id;
          proc_nxt = in_proc;
          size_nxt = in_request_size;
          va_nxt   = in_virtual_address;
          wb_nxt   = in_write_byte;
          if (pid_bad) begin
            state_nxt = pawt_pkg::S_REJECT;
          end else begin
            case (in_command)
              pawt_pkg::CMD_ALLOC: state_nxt = pawt_pkg::S_ALLOC_CHK;
              pawt_pkg::CMD_FREE:  state_nxt = pawt_pkg::S_FREE_LK;
              default:             state_nxt = pawt_pkg::S_RW_LK;
            endcase
          end
        end
      end

      // unknown process
      pawt_pkg::S_REJECT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = (cmd_r == pawt_pkg::CMD_ALLOC) ? pawt_pkg::ST_NO_MEM
                                                        : pawt_pkg::ST_UNMAPPED;
        out_region_nxt = 16'd0;
        out_byte_nxt   = 8'd0;
        state_nxt      = pawt_pkg::S_IDLE;
      end

      // check space, advance the break pointer
      pawt_pkg::S_ALLOC_CHK: begin
        if (alloc_fail) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pawt_pkg::ST_NO_MEM;
          out_region_nxt = 16'd0;
          out_byte_nxt   = 8'd0;
          state_nxt      = pawt_pkg::S_IDLE;
        end else begin
          bp_we      = 1'b1;
          need_nxt   = need_w;
          region_nxt = bp_cur[15:0];
          pg_nxt     = '0;
          k_nxt      = '0;
          vcur_nxt   = bp_cur[16:OFB];
          if (need_w == 10'd0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pawt_pkg::ST_OK;
            out_region_nxt = bp_cur[15:0];
            out_byte_nxt   = 8'd0;
            state_nxt      = pawt_pkg::S_IDLE;
          end else begin
            state_nxt = pawt_pkg::S_ALLOC_RD;
          end
        end
      end

      // read owner of the next page
      pawt_pkg::S_ALLOC_RD: begin
        state_nxt = pawt_pkg::S_ALLOC_TST;
      end

      // claim the page if free, link and map it
      pawt_pkg::S_ALLOC_TST: begin
        pg_nxt = pg_inc;
        if (page_free) begin
          own_we   = 1'b1;
          own_wd   = pid_r;
          lnk_we   = (k_r != '0);
          map_we   = (32'(vcur_r) < (1 << VPB));
          map_wd   = {1'b1, pg_r[PGW-1:0]};
          prev_nxt = pg_r[PGW-1:0];
          k_nxt    = k_inc;
          vcur_nxt = vcur_r + (VPB+1)'(1);
          free_nxt = free_r - LW'(1);
        end
        if ((page_free && (CMPW'(k_inc) == CMPW'(need_r))) ||
            (32'(pg_inc) == PHYS_PAGES)) begin
          state_nxt = pawt_pkg::S_ALLOC_END;
        end else begin
          state_nxt = pawt_pkg::S_ALLOC_RD;
        end
      end

      // terminate the chain
      pawt_pkg::S_ALLOC_END: begin
        lnk_we         = (k_r != '0);
        lnk_wd         = LW'(PHYS_PAGES);
        out_valid_nxt  = 1'b1;
        out_status_nxt = pawt_pkg::ST_OK;
        out_region_nxt = region_r;
        out_byte_nxt   = 8'd0;
        state_nxt      = pawt_pkg::S_IDLE;
      end

      // first page of the chain to free
      pawt_pkg::S_FREE_LK: begin
        if (!map_rd[MEW-1]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pawt_pkg::ST_UNMAPPED;
          out_region_nxt = 16'd0;
          out_byte_nxt   = 8'd0;
          state_nxt      = pawt_pkg::S_IDLE;
        end else begin
          pg_nxt    = LW'(map_rd[PGW-1:0]);
          k_nxt     = '0;
          vcur_nxt  = {1'b0, va_r[15:OFB]};
          state_nxt = pawt_pkg::S_FREE_TST;
        end
      end

      // walk bounds, issue map, owner and link reads
      pawt_pkg::S_FREE_TST: begin
        if ((32'(k_r) < PHYS_PAGES) && (32'(pg_r) < PHYS_PAGES) &&
            (32'(vcur_r) < (1 << VPB))) begin
          state_nxt = pawt_pkg::S_FREE_CHK;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pawt_pkg::ST_OK;
          out_region_nxt = 16'd0;
          out_byte_nxt   = 8'd0;
          state_nxt      = pawt_pkg::S_IDLE;
        end
      end

      // release the page while map and owner still agree
      pawt_pkg::S_FREE_CHK: begin
        if ((map_rd == {1'b1, pg_r[PGW-1:0]}) && (own_rd == pid_r)) begin
          own_we    = 1'b1;
          own_wd    = 4'd0;
          map_we    = 1'b1;
          map_wd    = '0;
          free_nxt  = free_r + LW'(1);
          pg_nxt    = lnk_rd;
          k_nxt     = k_inc;
          vcur_nxt  = vcur_r + (VPB+1)'(1);
          state_nxt = pawt_pkg::S_FREE_TST;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pawt_pkg::ST_OK;
          out_region_nxt = 16'd0;
          out_byte_nxt   = 8'd0;
          state_nxt      = pawt_pkg::S_IDLE;
        end
      end

      // translate, then write or start the byte read
      pawt_pkg::S_RW_LK: begin
        if (!map_rd[MEW-1]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pawt_pkg::ST_UNMAPPED;
          out_region_nxt = 16'd0;
          out_byte_nxt   = 8'd0;
          state_nxt      = pawt_pkg::S_IDLE;
        end else if (cmd_r == pawt_pkg::CMD_WRITE) begin
          byt_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = pawt_pkg::ST_OK;
          out_region_nxt = 16'd0;
          out_byte_nxt   = 8'd0;
          state_nxt      = pawt_pkg::S_IDLE;
        end else begin
          state_nxt = pawt_pkg::S_RD_WAIT;
        end
      end

      // return the byte
      pawt_pkg::S_RD_WAIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = pawt_pkg::ST_OK;
        out_region_nxt = 16'd0;
        out_byte_nxt   = byt_rd;
        state_nxt      = pawt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = pawt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != pawt_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_region_address = out_region_r;
  assign out_read_byte      = out_byte_r;

  // checks
  `PAWT_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `PAWT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `PAWT_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, 32'(free_r) <= PHYS_PAGES)
  `PAWT_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
                   out_status != 2'd3)

endmodule

/* tb/sv/pawt_checker.sv */
`timescale 1ns / 100ps
module pawt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_process_id,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_virtual_address,
  input  logic [7:0]  in_write_byte,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_region_address,
  input  logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_heap_start,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  localparam int NPAGES = 256;
  localparam int NPROC  = 8;
  localparam int OFB    = pawt_pkg::OFFSET_BITS;
  localparam int VPAGES = 1 << pawt_pkg::VPAGE_BITS;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] region;
    logic [7:0]  rdata;
  } reply_t;

  reply_t      reply_q[$];
  logic [3:0]  owner[NPAGES];
  logic [8:0]  link[NPAGES];
  int          free_cnt;
  logic [16:0] brk[NPROC];
  logic        map_ok[NPROC*VPAGES];
  logic [7:0]  map_pg[NPROC*VPAGES];
  logic [7:0]  mem[NPAGES*256];

  // Map a virtual address to a physical byte; returns 0 when unmapped.
  function automatic bit translate(int p, logic [15:0] va, output int pa);
    int slot;
    slot = p * VPAGES + int'(va[15:OFB]);
    pa = (int'(map_pg[slot]) << OFB) | int'(va[OFB-1:0]);
    return map_ok[slot];
  endfunction

  // Apply one request to the shadow state and return its reply.
  function automatic reply_t execute_request(logic [1:0] cmd, logic [3:0] pid,
                                             logic [16:0] size, logic [15:0] va,
                                             logic [7:0] wb);
    reply_t r;
    int p, pa, need, vstart, k, pg, prev, vp, slot;
    r = '0;
    if (pid == 0 || pid > NPROC) begin
      r.status = (cmd == pawt_pkg::CMD_ALLOC) ? pawt_pkg::ST_NO_MEM : pawt_pkg::ST_UNMAPPED;
      return r;
    end
    p = int'(pid) - 1;
    case (cmd)
      pawt_pkg::CMD_ALLOC: begin
        need = (int'(size) + 255) >> OFB;
        if (need > free_cnt || int'(brk[p]) + need * 256 > 65536) begin
          r.status = pawt_pkg::ST_NO_MEM;
        end else begin
          vstart = int'(brk[p]) >> OFB;
          k = 0;
          prev = 0;
          for (pg = 0; pg < NPAGES && k < need; pg++) begin
            if (owner[pg] != 0) continue;
            owner[pg] = pid;
            if (k > 0) link[prev] = 9'(pg);
            if (vstart + k < VPAGES) begin
              map_ok[p*VPAGES + vstart + k] = 1'b1;
              map_pg[p*VPAGES + vstart + k] = 8'(pg);
            end
            prev = pg;
            k++;
          end
          if (k > 0) link[prev] = 9'(NPAGES);
          free_cnt -= k;
          r.region = brk[p][15:0];
          brk[p] = 17'(int'(brk[p]) + need * 256);
        end
      end
      pawt_pkg::CMD_FREE: begin
        if (!translate(p, va, pa)) begin
          r.status = pawt_pkg::ST_UNMAPPED;
        end else begin
          vp = int'(va[15:OFB]);
          pg = pa >> OFB;
          k = 0;
          while (k < NPAGES && pg < NPAGES && vp + k < VPAGES) begin
            slot = p * VPAGES + vp + k;
            if (!map_ok[slot] || int'(map_pg[slot]) != pg || owner[pg] != pid) break;
            owner[pg] = 0;
            free_cnt++;
            map_ok[slot] = 1'b0;
            pg = int'(link[pg]);
            k++;
          end
        end
      end
      default: begin
        if (!translate(p, va, pa)) r.status = pawt_pkg::ST_UNMAPPED;
        else if (cmd == pawt_pkg::CMD_READ) r.rdata = mem[pa];
        else mem[pa] = wb;
      end
    endcase
    return r;
  endfunction

  // Reset the shadow state.
  initial begin
    for (int i = 0; i < NPAGES; i++) begin
      owner[i] = 0;
      link[i] = 0;
    end
    for (int i = 0; i < NPROC*VPAGES; i++) begin
      map_ok[i] = 0;
      map_pg[i] = 0;
    end
    for (int i = 0; i < NPAGES*256; i++) mem[i] = 0;
    for (int i = 0; i < NPROC; i++) brk[i] = {1'b0, pawt_pkg::HEAP_RESET};
    free_cnt = NPAGES;
  end

  // Watch requests, config writes and replies.
  always @(posedge clk) begin
    reply_t got, exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        for (int i = 0; i < NPROC; i++) brk[i] = {1'b0, cfg_heap_start};
      if (out_valid) begin
        got = '{out_status, out_region_address, out_read_byte};
        result_count++;
        if (reply_q.size() == 0) begin
          $error("reply with no request outstanding");
          fail_count++;
        end else begin
          exp_r = reply_q.pop_front();
          if (got.status != exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            fail_count++;
          end
          if (got.region != exp_r.region) begin
            $error("region_address: expected %0h, got %0h", exp_r.region, got.region);
            fail_count++;
          end
          if (got.rdata != exp_r.rdata) begin
            $error("read_byte: expected %0h, got %0h", exp_r.rdata, got.rdata);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        reply_q.push_back(execute_request(in_command, in_process_id, in_request_size,
                                          in_virtual_address, in_write_byte));
      pending_count = reply_q.size();
    end
  end
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
module testbench;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [3:0]  in_process_id;
  logic [16:0] in_request_size;
  logic [15:0] in_virtual_address;
  logic [7:0]  in_write_byte;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_region_address;
  logic [7:0]  out_read_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_heap_start;
  int          fail_count;
  int          pending_count;
  int          result_count;

  // Regions handed out per process, for well-formed follow-ups.
  logic [15:0] region_base[8][$];
  int          region_len[8][$];
  int          burst_left;

  paged_allocator_with_translation_top uut (.*);

  pawt_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Issue one request; hold start until it is taken.
  task automatic send_request(logic [1:0] cmd, logic [3:0] pid, logic [16:0] size,
                              logic [15:0] va, logic [7:0] wb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_command <= cmd;
    in_process_id <= pid;
    in_request_size <= size;
    in_virtual_address <= va;
    in_write_byte <= wb;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for all replies, then write heap_start.
  task automatic write_heap(logic [15:0] value);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_heap_start <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int p = 0; p < 8; p++) begin
      region_base[p].delete();
      region_len[p].delete();
    end
  endtask

  // Random request, mostly aimed at regions already handed out.
  task automatic random_request();
    int p, n, pick, off;
    logic [3:0] pid;
    logic [1:0] cmd;
    logic [16:0] size;
    logic [15:0] va;
    p = $urandom_range(0, 7);
    pid = 4'(p + 1);
    pick = $urandom_range(0, 99);
    va = 16'($urandom);
    size = (pick < 3) ? 17'($urandom) : 17'($urandom_range(0, 2048));
    if (pick < 2) pid = 4'($urandom_range(0, 15));
    cmd = (pick < 22) ? pawt_pkg::CMD_ALLOC : (pick < 30) ? pawt_pkg::CMD_FREE :
          (pick < 65) ? pawt_pkg::CMD_READ : pawt_pkg::CMD_WRITE;
    n = region_base[p].size();
    if (n > 0 && pick >= 22 && $urandom_range(0, 9) != 0) begin
      off = $urandom_range(0, n - 1);
      va = 16'(int'(region_base[p][off]) + ((cmd == pawt_pkg::CMD_FREE) ? 0 :
           int'($urandom_range(0, region_len[p][off] - 1))));
      if (cmd == pawt_pkg::CMD_FREE) begin
        region_base[p].delete(off);
        region_len[p].delete(off);
      end
    end
    if (cmd == pawt_pkg::CMD_ALLOC && size != 0 && int'(pid) == p + 1 && n < 16) begin
      region_base[p].push_back(chk.brk[p][15:0]);
      region_len[p].push_back(((int'(size) + 255) / 256) * 256);
    end
    send_request(cmd, pid, size, va, 8'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_heap_start = pawt_pkg::HEAP_RESET;
    in_command = pawt_pkg::CMD_READ;
    in_process_id = 0;
    in_request_size = 0;
    in_virtual_address = 0;
    in_write_byte = 0;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every command, each corner case.
    send_request(pawt_pkg::CMD_ALLOC, 1, 0, 0, 0);
    send_request(pawt_pkg::CMD_ALLOC, 1, 1, 0, 0);
    send_request(pawt_pkg::CMD_WRITE, 1, 0, 16'h0100, 8'hFF);
    send_request(pawt_pkg::CMD_READ, 1, 0, 16'h0100, 0);
    send_request(pawt_pkg::CMD_READ, 1, 0, 16'hFFFF, 0);
    send_request(pawt_pkg::CMD_ALLOC, 0, 5, 0, 0);
    send_request(pawt_pkg::CMD_READ, 15, 0, 16'h0100, 0);
    send_request(pawt_pkg::CMD_FREE, 9, 0, 16'h0100, 0);
    send_request(pawt_pkg::CMD_ALLOC, 2, 17'h10000, 0, 0);
    send_request(pawt_pkg::CMD_ALLOC, 2, 17'h1FFFF, 0, 0);
    send_request(pawt_pkg::CMD_ALLOC, 3, 17'hFF00, 0, 0);
    send_request(pawt_pkg::CMD_WRITE, 3, 0, 16'hFFFF, 8'hA5);
    send_request(pawt_pkg::CMD_READ, 3, 0, 16'hFFFF, 0);
    send_request(pawt_pkg::CMD_FREE, 3, 0, 16'h0000, 0);
    send_request(pawt_pkg::CMD_FREE, 3, 0, 16'h8000, 0);
    send_request(pawt_pkg::CMD_FREE, 3, 0, 16'h0100, 0);
    send_request(pawt_pkg::CMD_FREE, 1, 0, 16'h0100, 0);
    send_request(pawt_pkg::CMD_FREE, 1, 0, 16'h0100, 0);
    send_request(pawt_pkg::CMD_ALLOC, 8, 17'h0300, 0, 0);
    send_request(pawt_pkg::CMD_WRITE, 8, 0, 16'h0255, 8'h5A);
    send_request(pawt_pkg::CMD_READ, 8, 0, 16'h0255, 0);
    write_heap(16'hFFFF);
    send_request(pawt_pkg::CMD_ALLOC, 4, 1, 0, 0);
    send_request(pawt_pkg::CMD_ALLOC, 4, 0, 0, 0);
    write_heap(16'h0000);
    send_request(pawt_pkg::CMD_ALLOC, 5, 17'h0100, 0, 0);
    send_request(pawt_pkg::CMD_READ, 5, 0, 16'h0000, 0);

    // Random phases under several heap settings.
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 220; i++) random_request();
      write_heap((ph == 3) ? 16'hF000 : 16'($urandom_range(0, 16'h8000)));
    end
    start <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("Run covered %0d replies over all commands and several heap settings.",
             result_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/pawt_pkg.sv
design/pawt_ram.sv
design/paged_allocator_with_translation_top.sv
tb/sv/pawt_checker.sv
tb/sv/testbench.sv
